[sv/json_string_unescape_utf8_unit_macros.svh]
// -----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent assertion forms for the checker of the unescape unit.
// -----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/jsu_pkg.sv]
// -----------------------------------------------------------------------------
// JSON string unescape package
// Types, character codes and small decode and encode functions shared by the unit.
// -----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxRes = 6;
  localparam int CntW   = 3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_BODY     = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX      = 4'd3,
    PH_LOOK_BSL = 4'd4,
    PH_LOOK_U   = 4'd5,
    PH_LOW_HEX  = 4'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BAD_ESC = 3'd2,
    KIND_BAD_UNI = 3'd3,
    KIND_UNTERM  = 3'd4
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Lim1      = 21'h80;
  localparam logic [20:0] Lim2      = 21'h800;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  typedef struct packed {
    logic            load;
    logic [CntW-1:0] count;
    res_t [MaxRes-1:0] item;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp < Lim1) begin
      u.len  = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < Lim2) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < SuppBase) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

[sv/json_string_unescape_utf8_unit.sv]
// -----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Takes the bytes of a JSON string literal one per transfer, opening quote
// first, and gives the decoded UTF-8 bytes followed by one status transfer
// for the closing quote or an error. Each input byte passes through an input
// register, a decode stage, a burst register and an output register. A byte
// is taken in every cycle as long as each byte yields at most one result and
// the output is not stalled; a byte that yields several results (up to six,
// around unicode escapes) holds the result path until all its results have
// gone out, and m_tlast marks the final result of each byte.
// -----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [2:0] m_tuser,   // kind
  output logic       m_tlast    // last
);

  jsu_pkg::burst_t burst;
  logic            burst_ready;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  jsu_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_ready (burst_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

[sv/jsu_decode.sv]
// -----------------------------------------------------------------------------
// JSON string unescape decoder
// Input register, decoder state and the logic that turns one text byte into
// a burst of up to six results.
// -----------------------------------------------------------------------------
module jsu_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // in_byte
  input  logic              burst_ready,
  output jsu_pkg::burst_t   burst
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;

  jsu_pkg::phase_t      phase, phase_next;
  logic [15:0]          hex_accum, hex_accum_next;
  logic [1:0]           digit_count, digit_count_next;
  logic [15:0]          pending_high, pending_high_next;

  jsu_pkg::hex_t        hx;
  logic [15:0]          acc_new;
  logic [20:0]          combined;
  logic                 pre;
  logic                 do_body;
  logic                 do_esc;
  logic                 do_finish;
  logic [15:0]          finish_cp;
  logic                 cp_en;
  logic [20:0]          cp;
  jsu_pkg::utf8_t       u_main;
  jsu_pkg::utf8_t       u_pfx;
  logic [2:0]           main_len;
  jsu_pkg::res_t [3:0]  main;

  assign advance  = in_valid && burst_ready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= jsu_pkg::PH_IDLE;
      hex_accum    <= '0;
      digit_count  <= '0;
      pending_high <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      hex_accum    <= hex_accum_next;
      digit_count  <= digit_count_next;
      pending_high <= pending_high_next;
    end
  end

  always_comb begin
    hx       = jsu_pkg::hex_decode(in_byte);
    acc_new  = {hex_accum[11:0], hx.val};
    combined = jsu_pkg::SuppBase + {1'b0, pending_high[9:0], acc_new[9:0]};

    phase_next        = phase;
    hex_accum_next    = hex_accum;
    digit_count_next  = digit_count;
    pending_high_next = pending_high;

    pre       = 1'b0;
    do_body   = 1'b0;
    do_esc    = 1'b0;
    do_finish = 1'b0;
    finish_cp = acc_new;
    cp_en     = 1'b0;
    cp        = '0;
    main_len  = 3'd0;
    main      = '0;

    unique case (phase)
      jsu_pkg::PH_BODY: begin
        do_body = 1'b1;
      end
      jsu_pkg::PH_ESC: begin
        do_esc = 1'b1;
      end
      jsu_pkg::PH_HEX: begin
        if (!hx.ok) begin
          main_len  = 3'd1;
          main[0]   = '{data: 8'd0, kind: jsu_pkg::KIND_BAD_UNI};
          phase_next        = jsu_pkg::PH_IDLE;
          hex_accum_next    = '0;
          digit_count_next  = '0;
          pending_high_next = '0;
        end else if (digit_count == 2'd3) begin
          do_finish = 1'b1;
        end else begin
          hex_accum_next   = acc_new;
          digit_count_next = digit_count + 2'd1;
        end
      end
      jsu_pkg::PH_LOOK_BSL: begin
        if (in_byte == jsu_pkg::CH_BSL) begin
          phase_next = jsu_pkg::PH_LOOK_U;
        end else begin
          pre               = 1'b1;
          pending_high_next = '0;
          do_body           = 1'b1;
        end
      end
      jsu_pkg::PH_LOOK_U: begin
        if (in_byte == jsu_pkg::CH_U) begin
          phase_next       = jsu_pkg::PH_LOW_HEX;
          hex_accum_next   = '0;
          digit_count_next = '0;
        end else begin
          pre               = 1'b1;
          pending_high_next = '0;
          do_esc            = 1'b1;
        end
      end
      jsu_pkg::PH_LOW_HEX: begin
        if (!hx.ok) begin
          pre      = 1'b1;
          main_len = 3'd1;
          main[0]  = '{data: 8'd0, kind: jsu_pkg::KIND_BAD_UNI};
          phase_next        = jsu_pkg::PH_IDLE;
          hex_accum_next    = '0;
          digit_count_next  = '0;
          pending_high_next = '0;
        end else if (digit_count == 2'd3) begin
          pending_high_next = '0;
          if (acc_new >= jsu_pkg::LowFirst && acc_new <= jsu_pkg::LowLast) begin
            cp_en            = 1'b1;
            cp               = combined;
            hex_accum_next   = '0;
            digit_count_next = '0;
            phase_next       = jsu_pkg::PH_BODY;
          end else begin
            pre       = 1'b1;
            do_finish = 1'b1;
          end
        end else begin
          hex_accum_next   = acc_new;
          digit_count_next = digit_count + 2'd1;
        end
      end
      default: begin
        phase_next        = jsu_pkg::PH_BODY;
        hex_accum_next    = '0;
        digit_count_next  = '0;
        pending_high_next = '0;
      end
    endcase

    if (do_body) begin
      phase_next = jsu_pkg::PH_BODY;
      if (in_byte == jsu_pkg::CH_NUL || in_byte == jsu_pkg::CH_QUOTE) begin
        main_len = 3'd1;
        main[0]  = '{data: 8'd0,
                     kind: (in_byte == jsu_pkg::CH_NUL) ? jsu_pkg::KIND_UNTERM
                                                        : jsu_pkg::KIND_DONE};
        phase_next        = jsu_pkg::PH_IDLE;
        hex_accum_next    = '0;
        digit_count_next  = '0;
        pending_high_next = '0;
      end else if (in_byte == jsu_pkg::CH_BSL) begin
        phase_next = jsu_pkg::PH_ESC;
      end else begin
        main_len = 3'd1;
        main[0]  = '{data: in_byte, kind: jsu_pkg::KIND_DATA};
      end
    end

    if (do_esc) begin
      main_len   = 3'd1;
      phase_next = jsu_pkg::PH_BODY;
      unique case (in_byte)
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
          main[0] = '{data: in_byte, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_B: begin
          main[0] = '{data: 8'h08, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_F: begin
          main[0] = '{data: 8'h0C, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_N: begin
          main[0] = '{data: 8'h0A, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_R: begin
          main[0] = '{data: 8'h0D, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_T: begin
          main[0] = '{data: 8'h09, kind: jsu_pkg::KIND_DATA};
        end
        jsu_pkg::CH_U: begin
          main_len         = 3'd0;
          phase_next       = jsu_pkg::PH_HEX;
          hex_accum_next   = '0;
          digit_count_next = '0;
        end
        default: begin
          main[0]           = '{data: 8'd0, kind: jsu_pkg::KIND_BAD_ESC};
          phase_next        = jsu_pkg::PH_IDLE;
          hex_accum_next    = '0;
          digit_count_next  = '0;
          pending_high_next = '0;
        end
      endcase
    end

    if (do_finish) begin
      hex_accum_next   = '0;
      digit_count_next = '0;
      if (finish_cp >= jsu_pkg::HighFirst && finish_cp <= jsu_pkg::HighLast) begin
        pending_high_next = finish_cp;
        phase_next        = jsu_pkg::PH_LOOK_BSL;
      end else begin
        cp_en      = 1'b1;
        cp         = {5'd0, finish_cp};
        phase_next = jsu_pkg::PH_BODY;
      end
    end

    u_main = jsu_pkg::utf8_encode(cp);
    if (cp_en) begin
      main_len = u_main.len;
      for (int i = 0; i < 4; i++) begin
        main[i] = '{data: u_main.b[i], kind: jsu_pkg::KIND_DATA};
      end
    end
  end

  // A pending high surrogate always encodes as three bytes.
  assign u_pfx = jsu_pkg::utf8_encode({5'd0, pending_high});

  always_comb begin
    burst.load = advance;
    if (pre) begin
      burst.count   = main_len + 3'd3;
      burst.item[0] = '{data: u_pfx.b[0], kind: jsu_pkg::KIND_DATA};
      burst.item[1] = '{data: u_pfx.b[1], kind: jsu_pkg::KIND_DATA};
      burst.item[2] = '{data: u_pfx.b[2], kind: jsu_pkg::KIND_DATA};
      burst.item[3] = main[0];
      burst.item[4] = main[1];
      burst.item[5] = main[2];
    end else begin
      burst.count   = main_len;
      burst.item[0] = main[0];
      burst.item[1] = main[1];
      burst.item[2] = main[2];
      burst.item[3] = main[3];
      burst.item[4] = '0;
      burst.item[5] = '0;
    end
  end

endmodule

[sv/jsu_burst.sv]
// -----------------------------------------------------------------------------
// JSON string unescape result burst
// Holds the results of one byte and hands them one at a time to the output
// register.
// -----------------------------------------------------------------------------
module jsu_burst (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::burst_t     burst,
  output logic                burst_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // out_byte
  output logic [2:0]          m_tuser,   // kind
  output logic                m_tlast
);

  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0] item;
  logic [jsu_pkg::CntW-1:0]            count;
  logic                                pop;

  assign pop         = (count != '0) && (!m_tvalid || m_tready);
  assign burst_ready = (count == '0) || (pop && count == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (burst.load && burst_ready) begin
      count <= burst.count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load && burst_ready) begin
      item <= burst.item;
    end else if (pop) begin
      for (int i = 0; i < jsu_pkg::MaxRes - 1; i++) begin
        item[i] <= item[i+1];
      end
      item[jsu_pkg::MaxRes-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= item[0].data;
      m_tuser <= item[0].kind;
      m_tlast <= (count == 3'd1);
    end
  end

endmodule

[sv/jsu_checker.sv]
// -----------------------------------------------------------------------------
// JSON string unescape port checker
// Watches the output ports of the unescape unit over time.
// -----------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  logic        stalled;
  logic        status;
  logic [11:0] out_word;

  assign stalled  = m_tvalid && !m_tready;
  assign status   = m_tvalid && (m_tuser != jsu_pkg::KIND_DATA);
  assign out_word = {m_tdata, m_tuser, m_tlast};

  `JSU_ASSERT_NEXT(a_hold_valid, clk, rst, stalled, m_tvalid)
  `JSU_ASSERT_NEXT(a_hold_data, clk, rst, stalled, $stable(out_word))
  `JSU_ASSERT_SAME(a_status_last, clk, rst, status, m_tlast)
  `JSU_ASSERT_SAME(a_status_zero, clk, rst, status, m_tdata == 8'd0)

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);
